@@ src/known_plaintext_key_search_unit_assert.svh @@
// Assertion shorthands used by the checker file kpks_sva.sv.
`ifndef KNOWN_PLAINTEXT_KEY_SEARCH_UNIT_ASSERT_SVH
`define KNOWN_PLAINTEXT_KEY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define KPKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define KPKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/kpks_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kpks_pkg;

  localparam int MAX_WORDS = 64;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int WORD_W    = 32;
  localparam int ROT_W     = 8;
  localparam int MIN_PAIRS = 3;

  typedef struct packed {
    logic [WORD_W-1:0] plain_word;
    logic [WORD_W-1:0] cipher_word;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] key_a;
    logic [WORD_W-1:0] key_b;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROT_W-1:0]  rot;
    logic              calc_d;
    logic              load_trial;
    logic              mix1;
    logic              mix2;
    logic              take_best;
    logic              clr_best;
    logic              emit;
    logic              overflow;
  } ctrl_cmd_t;

  typedef struct packed {
    logic d_match;
    logic pair_match;
  } ctrl_stat_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/known_plaintext_key_search_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// in_       in_valid / in_stall  in_item  (plain_word, cipher_word, last_word)
// out_      out_valid / out_stall out_item (found, key_a, key_b, overflow)
//
// Each pair is written to the pair store while it has room, else dropped
// and flagged as overflow. After a last pair the input stalls while the
// search runs: each of the 256 rotate amounts passes CAND and TEST, and
// each kept candidate replays the stored pairs through one read port.
// Reset is synchronous and active low; the pair store needs no clearing.
// A result waits in the output register under out_stall while new pairs load.
module known_plaintext_key_search_unit import kpks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  kpks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .last_word (in_item.last_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  kpks_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

@@ src/kpks_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kpks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ src/kpks_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kpks_datapath import kpks_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  input  in_item_t   in_item,
  output ctrl_stat_t stat,
  output out_item_t  out_item
);

  logic [2*WORD_W-1:0] rd_data;
  logic [WORD_W-1:0]   rd_plain;
  logic [WORD_W-1:0]   rd_cipher;

  logic [WORD_W-1:0] a1_r;
  logic [WORD_W-1:0] a3_r;
  logic [WORD_W-1:0] d_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] ah_r;
  logic [WORD_W-1:0] bh_r;
  logic [WORD_W-1:0] trial_b_r;
  logic [WORD_W-1:0] best_b_r;
  logic              best_valid_r;
  out_item_t         out_item_r;

  logic [WORD_W-1:0] bh_nxt;
  logic [WORD_W-1:0] a_mix_nxt;
  logic [WORD_W-1:0] trial_nxt;

  kpks_ram #(
    .WIDTH(2 * WORD_W),
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data ({in_item.plain_word, in_item.cipher_word}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  assign rd_plain  = rd_data[2*WORD_W-1:WORD_W];
  assign rd_cipher = rd_data[WORD_W-1:0];

  // One keystream step is split into a mix1 and a mix2 step: rotate and xor,
  // then rotate and add.
  assign bh_nxt    = rotl32(b_r, a_r[4:0]);
  assign a_mix_nxt = rotr32(ah_r, bh_r[12:8]);
  assign trial_nxt = rotr32(d_r, a1_r[4:0]);

  assign stat.d_match    = (d_r[15:8] == cmd.rot);
  assign stat.pair_match = ((rd_plain ^ a_r) == rd_cipher);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (cmd.wr_addr == ADDR_W'(0))) begin
      a1_r <= in_item.plain_word ^ in_item.cipher_word;
    end
    if (cmd.wr_en && (cmd.wr_addr == ADDR_W'(1))) begin
      a3_r <= in_item.plain_word ^ in_item.cipher_word;
    end
    if (cmd.calc_d) begin
      d_r <= rotl32(a3_r, cmd.rot[4:0]) ^ a1_r;
    end
    if (cmd.load_trial) begin
      trial_b_r <= trial_nxt;
      b_r       <= trial_nxt;
      a_r       <= a1_r;
    end else if (cmd.mix2) begin
      a_r <= a_mix_nxt;
      b_r <= bh_r + a_mix_nxt;
    end
    if (cmd.mix1) begin
      bh_r <= bh_nxt;
      ah_r <= a_r ^ bh_nxt;
    end
    if (cmd.clr_best) begin
      best_b_r <= '0;
    end else if (cmd.take_best && (!best_valid_r || (trial_b_r < best_b_r))) begin
      best_b_r <= trial_b_r;
    end
    if (cmd.emit) begin
      out_item_r.found    <= best_valid_r;
      out_item_r.key_a    <= best_valid_r ? a1_r : '0;
      out_item_r.key_b    <= best_valid_r ? best_b_r : '0;
      out_item_r.overflow <= cmd.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.clr_best) begin
      best_valid_r <= 1'b0;
    end else if (cmd.take_best) begin
      best_valid_r <= 1'b1;
    end
  end

  assign out_item = out_item_r;

endmodule
`default_nettype wire

@@ src/kpks_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kpks_ctrl import kpks_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       last_word,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAND = 3'd1;
  localparam logic [2:0] ST_TEST = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_MIX  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ROT_W-1:0]  rot_r, rot_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              dropped_r, dropped_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic             full;
  logic             k_last;
  logic [CNT_W-1:0] count_after;

  assign full        = (count_r == CNT_W'(MAX_WORDS));
  assign count_after = full ? count_r : count_r + CNT_W'(1);
  assign k_last      = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    rot_nxt       = rot_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.rot       = rot_r;
    cmd.wr_addr   = count_r[ADDR_W-1:0];
    cmd.rd_addr   = k_r;
    cmd.overflow  = dropped_r;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!full) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_after;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (last_word) begin
            cmd.clr_best = 1'b1;
            rot_nxt      = '0;
            state_nxt    = (count_after >= CNT_W'(MIN_PAIRS)) ? ST_CAND : ST_EMIT;
          end
        end
      end
      ST_CAND: begin
        cmd.calc_d = 1'b1;
        state_nxt  = ST_TEST;
      end
      ST_TEST: begin
        if (stat.d_match) begin
          // Start the replay: fetch the first pair while the trial key loads.
          cmd.load_trial = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_addr    = '0;
          k_nxt          = '0;
          state_nxt      = ST_CHK;
        end else if (rot_r == '1) begin
          state_nxt = ST_EMIT;
        end else begin
          rot_nxt   = rot_r + ROT_W'(1);
          state_nxt = ST_CAND;
        end
      end
      ST_CHK: begin
        if (stat.pair_match && !k_last) begin
          cmd.mix1    = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k_r + ADDR_W'(1);
          k_nxt       = k_r + ADDR_W'(1);
          state_nxt   = ST_MIX;
        end else begin
          cmd.take_best = stat.pair_match;
          if (rot_r == '1) begin
            state_nxt = ST_EMIT;
          end else begin
            rot_nxt   = rot_r + ROT_W'(1);
            state_nxt = ST_CAND;
          end
        end
      end
      ST_MIX: begin
        cmd.mix2  = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          dropped_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      k_r         <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ src/kpks_sva.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "known_plaintext_key_search_unit_assert.svh"
module kpks_sva import kpks_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A held result stays offered.
  `KPKS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // A held result does not change.
  `KPKS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item), "result changed under stall")

  // After a last item the unit leaves idle, to search or to emit, so the input closes.
  `KPKS_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_item.last_word, in_stall, "input open after last item")

  // Keys read as zero when nothing was found.
  `KPKS_ASSERT_NOW(a_zero_keys, out_valid && !out_item.found, (out_item.key_a == '0) && (out_item.key_b == '0), "keys not zero without a find")

endmodule

bind known_plaintext_key_search_unit kpks_sva u_sva (.*);
`default_nettype wire
